@@ rtl/core/rcr_pkg.sv @@
// Shared types and constants for the rainbow color ramp.
// Used by rcr_div_cell, rcr_shade and rainbow_color_ramp_unit; no dependencies.
package rcr_pkg;

	localparam int SAMPLE_W = 32;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 1;

	// range_status codes
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BELOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EQUAL = 2'd3;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_LOW  = 1'd0;
	localparam logic [INDEX_W-1:0] REG_HIGH = 1'd1;

	typedef logic [SAMPLE_W-1:0] mag_t;

	// class of a beat as it travels down the divider chain
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                unity;  // |sample - low| equals |high - low|
	} div_tag_t;

endpackage

@@ rtl/core/rcr_div_cell.sv @@
// One restoring division cell: produces one quotient bit per beat and
// hands remainder, divisor and partial quotient to the next cell. Uses rcr_pkg.
module rcr_div_cell #(
	parameter int QW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rcr_pkg::mag_t     in_r,
	input  rcr_pkg::mag_t     in_d,
	input  logic [QW-1:0]     in_q,
	input  rcr_pkg::div_tag_t in_tag,
	output logic              out_valid,
	input  logic              out_ready,
	output rcr_pkg::mag_t     out_r,
	output rcr_pkg::mag_t     out_d,
	output logic [QW-1:0]     out_q,
	output rcr_pkg::div_tag_t out_tag
);
	import rcr_pkg::*;

	logic                  v_q;
	logic                  en;
	logic [SAMPLE_W+1:0]   trial;
	logic                  take;
	mag_t                  r_next;
	mag_t                  r_q;
	mag_t                  d_q;
	logic [QW-1:0]         q_q;
	div_tag_t              tag_q;

	// remainder stays below the divisor, so 2r - d fits the remainder width
	always_comb begin
		trial  = {1'b0, in_r, 1'b0} - {2'b00, in_d};
		take   = ~trial[SAMPLE_W+1];
		r_next = take ? trial[SAMPLE_W-1:0] : in_r << 1;
	end

	assign en       = ~v_q | out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			r_q   <= r_next;
			d_q   <= in_d;
			q_q   <= {in_q[QW-2:0], take};
			tag_q <= in_tag;
		end
	end

	assign out_valid = v_q;
	assign out_r     = r_q;
	assign out_d     = d_q;
	assign out_q     = q_q;
	assign out_tag   = tag_q;

endmodule

@@ rtl/core/rcr_shade.sv @@
// Ramp segment select and channel scaling for the rainbow color ramp:
// turns the fixed-point fraction into red, green and blue. Uses rcr_pkg.
module rcr_shade #(
	parameter int FRAC = 16,
	parameter int CH   = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [FRAC-1:0]              in_q,
	input  rcr_pkg::mag_t                in_r,
	input  rcr_pkg::div_tag_t            in_tag,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CH-1:0]                red,
	output logic [CH-1:0]                green,
	output logic [CH-1:0]                blue,
	output logic [rcr_pkg::STATUS_W-1:0] range_status
);
	import rcr_pkg::*;

	localparam int VW = FRAC + 1;
	localparam int PW = VW + CH;
	localparam logic [VW-1:0] ONE_V  = {1'b1, {FRAC{1'b0}}};
	localparam logic [VW-1:0] Q1     = ONE_V >> 2;
	localparam logic [VW-1:0] Q2     = ONE_V >> 1;
	localparam logic [VW-1:0] Q3     = Q1 + Q2;
	localparam logic [CH-1:0] CHMAX  = {CH{1'b1}};
	localparam logic [PW:0]   HALF_V = {{(PW-FRAC+1){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	logic              en1;
	logic              en2;
	logic              v1_q;
	logic              v2_q;
	logic [VW-1:0]     qq;
	logic              rem;
	logic              le1;
	logic              le2;
	logic              le3;
	logic              le4;
	logic [VW-1:0]     rd;
	logic [VW-1:0]     gr;
	logic [VW-1:0]     bl;
	logic [VW-1:0]     rd_s1;
	logic [VW-1:0]     gr_s1;
	logic [VW-1:0]     bl_s1;
	logic [STATUS_W-1:0] st_s1;
	logic [CH-1:0]     red_q;
	logic [CH-1:0]     green_q;
	logic [CH-1:0]     blue_q;
	logic [STATUS_W-1:0] st_q;

	function automatic logic [CH-1:0] to_channel(input logic [VW-1:0] v);
		logic [PW-1:0]   prod;
		logic [PW:0]     sum;
		logic [CH+1:0]   c;
		prod = PW'(v) * PW'(CHMAX);
		sum  = {1'b0, prod} + HALF_V;
		c    = sum[PW:FRAC];
		return (c > (CH+2)'(CHMAX)) ? CHMAX : c[CH-1:0];
	endfunction

	// fraction t = qq (+ sticky rem); t <= point is exact on the grid
	always_comb begin
		qq  = in_tag.unity ? ONE_V : {1'b0, in_q};
		rem = ~in_tag.unity & (|in_r);
		le1 = (qq < Q1) | ((qq == Q1) & ~rem);
		le2 = (qq < Q2) | ((qq == Q2) & ~rem);
		le3 = (qq < Q3) | ((qq == Q3) & ~rem);
		le4 = (qq < ONE_V) | ((qq == ONE_V) & ~rem);
		rd  = '0;
		gr  = '0;
		bl  = '0;
		case (in_tag.status)
			ST_RANGE: begin
				if (le1) begin
					gr = qq << 2;
					bl = ONE_V;
				end else if (le2) begin
					gr = ONE_V;
					bl = (Q2 - qq) << 2;
				end else if (le3) begin
					rd = (qq - Q2) << 2;
					gr = ONE_V;
				end else if (le4) begin
					rd = ONE_V;
					gr = (ONE_V - qq) << 2;
				end else begin
					rd = ONE_V;
					gr = ONE_V;
					bl = ONE_V;
				end
			end
			ST_ABOVE: begin
				rd = ONE_V;
				gr = ONE_V;
				bl = ONE_V;
			end
			default: begin
				rd = '0;
			end
		endcase
	end

	assign en2      = ~v2_q | out_ready;
	assign en1      = ~v1_q | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= in_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			rd_s1 <= rd;
			gr_s1 <= gr;
			bl_s1 <= bl;
			st_s1 <= (in_tag.status == ST_RANGE && !le4) ? ST_ABOVE : in_tag.status;
		end
		if (en2 && v1_q) begin
			red_q   <= to_channel(rd_s1);
			green_q <= to_channel(gr_s1);
			blue_q  <= to_channel(bl_s1);
			st_q    <= st_s1;
		end
	end

	assign out_valid    = v2_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign range_status = st_q;

endmodule

@@ rtl/core/rainbow_color_ramp_unit.sv @@
// Rainbow color ramp top level: bound registers, normalizing front end,
// divider cell chain and shading stages. Uses rcr_pkg, rcr_div_cell, rcr_shade.
//
//  port group   dir  content (lowest bit up)
//  s_*          in   sample[31:0]
//  m_*          out  red, green, blue, range_status, zero pad to bytes
//  cfg_*        in   0 low_value, 1 high_value
//
// One beat accepted per clock while m_tready holds high; the pipeline holds one
// divider cell per fraction bit plus three front and two shade stages.
// Reset clears every stage valid and loads low_value 0, high_value 65535.
// A stall on m_tready fills empty stages first; s_tready falls only when every
// stage holds a beat.
module rainbow_color_ramp_unit #(
	parameter int FRACTION_BITS = 16,
	parameter int CHANNEL_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [rcr_pkg::SAMPLE_W-1:0] s_tdata,   // sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// red, green, blue, range_status
	output logic [((3 * CHANNEL_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
	input  logic                         cfg_we,
	input  logic [rcr_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [rcr_pkg::SAMPLE_W-1:0] cfg_data
);
	import rcr_pkg::*;

	localparam int NC      = FRACTION_BITS;
	localparam int TDATA_W = ((3 * CHANNEL_BITS + 2 + 7) / 8) * 8;

	logic [SAMPLE_W-1:0] low_q;
	logic [SAMPLE_W-1:0] high_q;

	logic              en1;
	logic              en2;
	logic              en3;
	logic              v1_q;
	logic              v2_q;
	logic              v3_q;
	logic [DIFF_W-1:0] xl_s1;
	logic [DIFF_W-1:0] dl_s1;
	mag_t              a_mag;
	mag_t              d_mag;
	mag_t              a_s2;
	mag_t              d_s2;
	logic              below_s2;
	logic              dzero_s2;
	mag_t              r_s3;
	mag_t              d_s3;
	div_tag_t          tag_s3;
	div_tag_t          tag_next;

	logic                     cv   [0:NC];
	logic                     crdy [0:NC];
	mag_t                     cr   [0:NC];
	mag_t                     cd   [0:NC];
	logic [FRACTION_BITS-1:0] cq   [0:NC];
	div_tag_t                 ctag [0:NC];

	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;
	logic [STATUS_W-1:0]     range_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= SAMPLE_W'(65535);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				default:  low_q  <= low_q;
			endcase
		end
	end

	// handshake chain: a stage advances when empty or when the next one advances
	assign en3      = ~v3_q | crdy[0];
	assign en2      = ~v2_q | en3;
	assign en1      = ~v1_q | en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= s_tvalid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_comb begin
		a_mag = xl_s1[DIFF_W-1] ? mag_t'(-xl_s1) : xl_s1[SAMPLE_W-1:0];
		d_mag = dl_s1[DIFF_W-1] ? mag_t'(-dl_s1) : dl_s1[SAMPLE_W-1:0];
	end

	always_comb begin
		tag_next.unity = (a_s2 == d_s2);
		if (dzero_s2) begin
			tag_next.status = ST_EQUAL;
		end else if (below_s2) begin
			tag_next.status = ST_BELOW;
		end else if (a_s2 > d_s2) begin
			tag_next.status = ST_ABOVE;
		end else begin
			tag_next.status = ST_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			xl_s1 <= {s_tdata[SAMPLE_W-1], s_tdata} - {low_q[SAMPLE_W-1], low_q};
			dl_s1 <= {high_q[SAMPLE_W-1], high_q} - {low_q[SAMPLE_W-1], low_q};
		end
		if (en2 && v1_q) begin
			a_s2     <= a_mag;
			d_s2     <= d_mag;
			below_s2 <= (xl_s1[DIFF_W-1] ^ dl_s1[DIFF_W-1]) & (|xl_s1);
			dzero_s2 <= ~(|dl_s1);
		end
		if (en3 && v2_q) begin
			r_s3   <= a_s2;
			d_s3   <= d_s2;
			tag_s3 <= tag_next;
		end
	end

	assign cv[0]   = v3_q;
	assign cr[0]   = r_s3;
	assign cd[0]   = d_s3;
	assign cq[0]   = '0;
	assign ctag[0] = tag_s3;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		rcr_div_cell #(
			.QW (FRACTION_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[i]),
			.in_ready  (crdy[i]),
			.in_r      (cr[i]),
			.in_d      (cd[i]),
			.in_q      (cq[i]),
			.in_tag    (ctag[i]),
			.out_valid (cv[i+1]),
			.out_ready (crdy[i+1]),
			.out_r     (cr[i+1]),
			.out_d     (cd[i+1]),
			.out_q     (cq[i+1]),
			.out_tag   (ctag[i+1])
		);
	end

	rcr_shade #(
		.FRAC (FRACTION_BITS),
		.CH   (CHANNEL_BITS)
	) u_shade (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (cv[NC]),
		.in_ready     (crdy[NC]),
		.in_q         (cq[NC]),
		.in_r         (cr[NC]),
		.in_tag       (ctag[NC]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.range_status (range_status)
	);

	assign m_tdata = TDATA_W'({range_status, blue, green, red});

	// divisor copy in the last cell is not needed downstream
	logic unused_d;
	assign unused_d = ^cd[NC];

endmodule
